[design/pdar_pkg.sv]
// Shared constants, payload types and stack control types for the pushdown recognizer.
package pdar_pkg;

  // Machine dimensions
  localparam int STATE_COUNT        = 16;
  localparam int STACK_SYMBOL_COUNT = 16;
  localparam int STACK_DEPTH        = 64;
  localparam int MAX_PUSH           = 4;

  // Field widths
  localparam int STATE_W    = 4;
  localparam int SYM_W      = 4;
  localparam int CHAR_W     = 8;
  localparam int OPCODE_W   = 2;
  localparam int COUNT_W    = 3;
  localparam int MASK_W     = 16;
  localparam int LIMIT_W    = 11;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Transition table is indexed by {state, top, character}
  localparam int TABLE_AW    = STATE_W + SYM_W + CHAR_W;
  localparam int TABLE_DEPTH = 1 << TABLE_AW;

  // Stack pointer holds 0..STACK_DEPTH
  localparam int SP_W       = $clog2(STACK_DEPTH + 1);
  localparam int PUSH_IDX_W = (MAX_PUSH > 1) ? $clog2(MAX_PUSH) : 1;

  // End-marker character '-'
  localparam logic [CHAR_W-1:0] END_MARK = 8'h2d;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SYMBOL = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT   = 8'd3;

  localparam logic [LIMIT_W-1:0] STEP_LIMIT_RESET = 11'd256;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_CHAR  = 2'd2,
    OP_END   = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [STATE_W-1:0]   key_state;
    logic [SYM_W-1:0]     key_top;
    logic [CHAR_W-1:0]    character;
    logic                 entry_valid;
    logic [STATE_W-1:0]   entry_next_state;
    logic [COUNT_W-1:0]   entry_push_count;
    logic [SYM_W-1:0]     push_first;
    logic [SYM_W-1:0]     push_second;
    logic [SYM_W-1:0]     push_third;
    logic [SYM_W-1:0]     push_fourth;
  } in_item_t;

  typedef struct packed {
    logic accepted;
    logic stack_overflowed;
    logic limit_reached;
  } out_item_t;

  // One transition; syms[0] ends on top of the stack
  typedef struct packed {
    logic                            valid;
    logic [STATE_W-1:0]              dest_state;
    logic [COUNT_W-1:0]              push_count;
    logic [MAX_PUSH-1:0][SYM_W-1:0]  syms;
  } table_entry_t;

  // Whole-stack operation requested by the sequencer
  typedef enum logic [1:0] {
    SOP_HOLD,
    SOP_PUSH,
    SOP_POP,
    SOP_LOAD
  } stack_op_t;

  typedef struct packed {
    stack_op_t         op;
    logic [SYM_W-1:0]  sym;
  } stack_ctl_t;

  // Per-cell move
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_ABOVE,
    CELL_FROM_BELOW
  } cell_op_t;

  // Key lies inside the configured state and symbol ranges
  function automatic logic key_in_range(input logic [STATE_W-1:0] st,
                                        input logic [SYM_W-1:0] top);
    return (int'(st) < STATE_COUNT) && (int'(top) < STACK_SYMBOL_COUNT);
  endfunction

endpackage

[design/pdar_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module pdar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/pdar_stack_cell.sv]
// One stack cell: holds a symbol, or takes it from the cell above or below.
module pdar_stack_cell (
  input  logic                      clk,
  input  pdar_pkg::cell_op_t        op,
  input  logic [pdar_pkg::SYM_W-1:0] above,
  input  logic [pdar_pkg::SYM_W-1:0] below,
  output logic [pdar_pkg::SYM_W-1:0] sym
);
  import pdar_pkg::*;

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_FROM_ABOVE: sym <= above;
      CELL_FROM_BELOW: sym <= below;
      CELL_HOLD:       sym <= sym;
      default:         sym <= sym;
    endcase
  end

endmodule

[design/pdar_stack.sv]
// Shift-chain stack: cell 0 is the top, pushes shift down, pops shift up.
module pdar_stack (
  input  logic                       clk,
  input  pdar_pkg::stack_ctl_t       ctl,
  output logic [pdar_pkg::SYM_W-1:0] top
);
  import pdar_pkg::*;

  logic [SYM_W-1:0] cell_sym [STACK_DEPTH];
  cell_op_t         op_top;
  cell_op_t         op_rest;

  // Map the stack operation onto the top cell and the cells below it
  always_comb begin
    op_top  = CELL_HOLD;
    op_rest = CELL_HOLD;
    unique case (ctl.op)
      SOP_PUSH: begin
        op_top  = CELL_FROM_ABOVE;
        op_rest = CELL_FROM_ABOVE;
      end
      SOP_POP: begin
        op_top  = CELL_FROM_BELOW;
        op_rest = CELL_FROM_BELOW;
      end
      SOP_LOAD: begin
        op_top  = CELL_FROM_ABOVE;
        op_rest = CELL_HOLD;
      end
      SOP_HOLD: begin
        op_top  = CELL_HOLD;
        op_rest = CELL_HOLD;
      end
      default: begin
        op_top  = CELL_HOLD;
        op_rest = CELL_HOLD;
      end
    endcase
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [SYM_W-1:0] above;
    logic [SYM_W-1:0] below;

    if (i == 0) begin : g_top
      assign above = ctl.sym;
    end else begin : g_mid
      assign above = cell_sym[i-1];
    end

    // Bottom cell refills from itself on a pop; its content is stale anyway
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign below = cell_sym[i];
    end else begin : g_inner
      assign below = cell_sym[i+1];
    end

    pdar_stack_cell u_cell (
      .clk   (clk),
      .op    ((i == 0) ? op_top : op_rest),
      .above (above),
      .below (below),
      .sym   (cell_sym[i])
    );
  end

  assign top = cell_sym[0];

endmodule

[design/pushdown_automaton_recognizer_core.sv]
// Top level of the deterministic pushdown recognizer: sequencer, table RAM and stack chain.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_item (pdar_pkg::in_item_t)
//   out     | output    | out_valid/out_stall| out_item (pdar_pkg::out_item_t)
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Reset starts a pass that marks every table entry invalid; in_stall stays high for it,
// config writes are taken. Write and start items need no further steps; a character does
// a table read and a stack update, then a push step for each pushed symbol past the first.
// End of word walks the end-marker transitions, each a check, a table lookup and the push
// steps, and ends at a check (empty stack) or a lookup (no transition, limit, overflow).
// A result stalled at the output holds the next end item in the done state, and the input.
module pushdown_automaton_recognizer_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pdar_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pdar_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pdar_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdar_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pdar_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_PUSH,
    ST_END_CHECK,
    ST_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [STATE_W-1:0] start_state;
  logic [SYM_W-1:0]   start_symbol;
  logic [MASK_W-1:0]  accept_mask;
  logic [LIMIT_W-1:0] step_limit;

  // Run state
  logic [STATE_W-1:0]    machine_state;
  logic [SP_W-1:0]       sp;
  logic                  input_left;
  logic                  run_halted;
  logic                  char_seen;
  logic                  overflow_seen;
  logic                  limit_seen;
  logic                  walking;
  logic                  lookup_ok;
  logic [LIMIT_W-1:0]    steps;
  logic [TABLE_AW-1:0]   clr_addr;
  logic [PUSH_IDX_W-1:0] push_idx;
  logic [MAX_PUSH-1:0][SYM_W-1:0] push_buf;

  // Table and stack wiring
  logic                wr_en;
  logic [TABLE_AW-1:0] wr_addr;
  table_entry_t        wr_entry;
  logic                rd_en;
  logic [TABLE_AW-1:0] rd_addr;
  logic [$bits(table_entry_t)-1:0] rd_data;
  table_entry_t        ent;
  stack_ctl_t          stack_ctl;
  logic [SYM_W-1:0]    top;

  logic                accept;
  logic [3:0][SYM_W-1:0] in_syms;
  logic [COUNT_W-1:0]  in_count;

  // Lookup decision in ST_EXEC
  logic [COUNT_W-1:0]  cnt;
  logic [COUNT_W-1:0]  cnt_m1;
  logic [SP_W:0]       sp_sum;
  logic                hit;
  logic                over_limit;
  logic                overflow;
  logic                fire;
  logic                out_free;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  // Entry built from a table-write item, push count saturated
  assign in_syms  = {in_item.push_fourth, in_item.push_third,
                     in_item.push_second, in_item.push_first};
  assign in_count = (int'(in_item.entry_push_count) > MAX_PUSH) ?
                    COUNT_W'(MAX_PUSH) : in_item.entry_push_count;

  always_comb begin
    wr_entry.valid      = in_item.entry_valid;
    wr_entry.dest_state = in_item.entry_next_state;
    wr_entry.push_count = in_count;
    for (int i = 0; i < MAX_PUSH; i++) begin
      wr_entry.syms[i] = in_syms[i];
    end
  end

  // Table write port: clearing sweep, then write items
  always_comb begin
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
    end else begin
      wr_en   = accept && (in_item.opcode == OP_WRITE) &&
                key_in_range(in_item.key_state, in_item.key_top);
      wr_addr = {in_item.key_state, in_item.key_top, in_item.character};
    end
  end

  // Table read port: word character on accept, end marker while walking
  assign rd_en   = (accept && (in_item.opcode == OP_CHAR)) || (state == ST_END_CHECK);
  assign rd_addr = (state == ST_END_CHECK) ? {machine_state, top, END_MARK}
                                           : {machine_state, top, in_item.character};

  pdar_ram #(
    .WIDTH ($bits(table_entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ((state == ST_CLEAR) ? '0 : wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Transition decision
  assign ent        = table_entry_t'(rd_data);
  assign cnt        = ent.push_count;
  assign cnt_m1     = cnt - 1'b1;
  assign sp_sum     = {1'b0, sp} + (SP_W + 1)'(cnt);
  assign hit        = ent.valid && lookup_ok;
  assign over_limit = walking && (steps >= step_limit);
  assign overflow   = sp_sum > (SP_W + 1)'(STACK_DEPTH + 1);
  assign fire       = hit && !over_limit && !overflow;

  // Stack chain control
  always_comb begin
    stack_ctl.op  = SOP_HOLD;
    stack_ctl.sym = start_symbol;
    priority case (state)
      ST_IDLE: begin
        if (accept && (in_item.opcode == OP_START)) begin
          stack_ctl.op  = SOP_LOAD;
          stack_ctl.sym = start_symbol;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          if (cnt == '0) begin
            stack_ctl.op = SOP_POP;
          end else begin
            // Pop and push of the deepest new symbol in one replace
            stack_ctl.op  = SOP_LOAD;
            stack_ctl.sym = ent.syms[cnt_m1[PUSH_IDX_W-1:0]];
          end
        end
      end
      ST_PUSH: begin
        stack_ctl.op  = SOP_PUSH;
        stack_ctl.sym = push_buf[push_idx];
      end
      default: begin
        stack_ctl.op  = SOP_HOLD;
        stack_ctl.sym = start_symbol;
      end
    endcase
  end

  pdar_stack u_stack (
    .clk (clk),
    .ctl (stack_ctl),
    .top (top)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_state  <= '0;
      start_symbol <= '0;
      accept_mask  <= '0;
      step_limit   <= STEP_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_STATE:  start_state  <= cfg_data[STATE_W-1:0];
        CFG_START_SYMBOL: start_symbol <= cfg_data[SYM_W-1:0];
        CFG_ACCEPT_MASK:  accept_mask  <= cfg_data[MASK_W-1:0];
        CFG_STEP_LIMIT:   step_limit   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Symbols still to push after the replace, no reset
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      push_buf <= ent.syms;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      machine_state <= '0;
      sp            <= '0;
      input_left    <= 1'b0;
      run_halted    <= 1'b0;
      char_seen     <= 1'b0;
      overflow_seen <= 1'b0;
      limit_seen    <= 1'b0;
      walking       <= 1'b0;
      lookup_ok     <= 1'b0;
      steps         <= '0;
      push_idx      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (accept) begin
            unique case (in_item.opcode)
              OP_WRITE: ;
              OP_START: begin
                machine_state <= start_state;
                sp            <= SP_W'(1);
                input_left    <= 1'b0;
                run_halted    <= 1'b0;
                char_seen     <= 1'b0;
                overflow_seen <= 1'b0;
                limit_seen    <= 1'b0;
              end
              OP_CHAR: begin
                char_seen <= 1'b1;
                walking   <= 1'b0;
                if (run_halted || sp == '0) begin
                  input_left <= 1'b1;
                  run_halted <= 1'b1;
                end else begin
                  lookup_ok <= key_in_range(machine_state, top);
                  state     <= ST_EXEC;
                end
              end
              OP_END: begin
                walking <= 1'b1;
                steps   <= '0;
                if (!char_seen || run_halted) begin
                  run_halted <= 1'b1;
                  state      <= ST_DONE;
                end else begin
                  state <= ST_END_CHECK;
                end
              end
              default: ;
            endcase
          end
        end

        // Issue the end-marker lookup unless the stack ran empty
        ST_END_CHECK: begin
          if (sp == '0) begin
            run_halted <= 1'b1;
            state      <= ST_DONE;
          end else begin
            lookup_ok <= key_in_range(machine_state, top);
            state     <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          if (!hit) begin
            if (walking) begin
              run_halted <= 1'b1;
              state      <= ST_DONE;
            end else begin
              input_left <= 1'b1;
              run_halted <= 1'b1;
              state      <= ST_IDLE;
            end
          end else if (over_limit) begin
            limit_seen <= 1'b1;
            run_halted <= 1'b1;
            state      <= ST_DONE;
          end else if (overflow) begin
            overflow_seen <= 1'b1;
            run_halted    <= 1'b1;
            state         <= walking ? ST_DONE : ST_IDLE;
          end else begin
            machine_state <= ent.dest_state;
            sp            <= SP_W'(sp_sum - 1'b1);
            if (walking) begin
              steps <= steps + 1'b1;
            end
            if (cnt > COUNT_W'(1)) begin
              push_idx <= PUSH_IDX_W'(cnt - COUNT_W'(2));
              state    <= ST_PUSH;
            end else begin
              state <= walking ? ST_END_CHECK : ST_IDLE;
            end
          end
        end

        // Remaining symbols, deepest first, the first one last on top
        ST_PUSH: begin
          if (push_idx == '0) begin
            state <= walking ? ST_END_CHECK : ST_IDLE;
          end else begin
            push_idx <= push_idx - 1'b1;
          end
        end

        // Result payload is registered here, no reset
        ST_DONE: begin
          if (out_free) begin
            out_valid                 <= 1'b1;
            out_item.accepted         <= !overflow_seen && !limit_seen && !input_left &&
                                         accept_mask[machine_state];
            out_item.stack_overflowed <= overflow_seen;
            out_item.limit_reached    <= limit_seen;
            state                     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[tb/tb_pushdown_automaton_recognizer_core.sv]
// Self-checking testbench for the pushdown recognizer core: queued stimulus and shadow model.
`timescale 1ns / 1ps

module tb_pushdown_automaton_recognizer_core;
  import pdar_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pushdown_automaton_recognizer_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock: 2 ns period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Stimulus and scoreboard stores
  in_item_t  pending_items[$];
  out_item_t expected_verdicts[$];
  int        queued_count;
  int        error_count;
  int        send_idle_pct;
  int        stall_pct;
  logic      item_taken;

  // Shadow copy of the recognizer
  table_entry_t       shadow_table [TABLE_DEPTH];
  logic [SYM_W-1:0]   shadow_stack [STACK_DEPTH];
  int unsigned        shadow_sp;
  logic [STATE_W-1:0] shadow_state;
  bit                 input_left;
  bit                 run_stopped;
  bit                 char_seen;
  bit                 overflow_hit;
  bit                 limit_hit;

  // Shadow configuration registers
  logic [STATE_W-1:0] reg_start_state;
  logic [SYM_W-1:0]   reg_start_symbol;
  logic [MASK_W-1:0]  reg_accept_mask;
  logic [LIMIT_W-1:0] reg_step_limit;

  // Per-phase working alphabet so that runs get past the first transitions
  logic [STATE_W-1:0] live_states [3];
  logic [SYM_W-1:0]   live_syms [3];
  logic [CHAR_W-1:0]  live_chars [3];

  // Pop the top, push the replacement symbols; returns 0 on stack overflow
  function automatic bit fire_transition(input table_entry_t e);
    int k;
    shadow_sp--;
    for (k = int'(e.push_count) - 1; k >= 0; k--) begin
      if (shadow_sp >= STACK_DEPTH) begin
        overflow_hit = 1'b1;
        run_stopped  = 1'b1;
        return 1'b0;
      end
      shadow_stack[shadow_sp] = e.syms[k];
      shadow_sp++;
    end
    shadow_state = e.dest_state;
    return 1'b1;
  endfunction

  // Advance the shadow machine by one transaction, queueing any verdict
  function automatic void predict_item(input in_item_t item);
    table_entry_t e;
    out_item_t    verdict;
    int unsigned  steps;
    case (item.opcode)
      OP_WRITE: begin
        e.valid      = item.entry_valid;
        e.dest_state = item.entry_next_state;
        e.push_count = (item.entry_push_count > MAX_PUSH) ? COUNT_W'(MAX_PUSH)
                                                           : item.entry_push_count;
        e.syms[0]    = item.push_first;
        e.syms[1]    = item.push_second;
        e.syms[2]    = item.push_third;
        e.syms[3]    = item.push_fourth;
        shadow_table[{item.key_state, item.key_top, item.character}] = e;
      end
      OP_START: begin
        shadow_state    = reg_start_state;
        shadow_stack[0] = reg_start_symbol;
        shadow_sp       = 1;
        input_left      = 1'b0;
        run_stopped     = 1'b0;
        char_seen       = 1'b0;
        overflow_hit    = 1'b0;
        limit_hit       = 1'b0;
      end
      OP_CHAR: begin
        char_seen = 1'b1;
        if (run_stopped || shadow_sp == 0) begin
          input_left  = 1'b1;
          run_stopped = 1'b1;
        end else begin
          e = shadow_table[{shadow_state, shadow_stack[shadow_sp-1], item.character}];
          if (!e.valid) begin
            input_left  = 1'b1;
            run_stopped = 1'b1;
          end else begin
            void'(fire_transition(e));
          end
        end
      end
      OP_END: begin
        if (!char_seen) begin
          // empty word: decided by the current state alone
          verdict.accepted         = reg_accept_mask[shadow_state];
          verdict.stack_overflowed = 1'b0;
          verdict.limit_reached    = 1'b0;
          run_stopped              = 1'b1;
        end else begin
          if (!run_stopped) begin
            // walk end-marker transitions up to the step limit
            steps = 0;
            while (shadow_sp > 0) begin
              e = shadow_table[{shadow_state, shadow_stack[shadow_sp-1], END_MARK}];
              if (!e.valid) break;
              if (steps >= reg_step_limit) begin
                limit_hit = 1'b1;
                break;
              end
              if (!fire_transition(e)) break;
              steps++;
            end
            run_stopped = 1'b1;
          end
          verdict.accepted         = !overflow_hit && !limit_hit && !input_left &&
                                     reg_accept_mask[shadow_state];
          verdict.stack_overflowed = overflow_hit;
          verdict.limit_reached    = limit_hit;
        end
        expected_verdicts = {expected_verdicts, verdict};
      end
    endcase
  endfunction

  // Monitor: register writes, accepted input transactions, result checks
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= in_valid && !in_stall;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_STATE:  reg_start_state  = cfg_data[STATE_W-1:0];
          CFG_START_SYMBOL: reg_start_symbol = cfg_data[SYM_W-1:0];
          CFG_ACCEPT_MASK:  reg_accept_mask  = cfg_data[MASK_W-1:0];
          CFG_STEP_LIMIT:   reg_step_limit   = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_item(in_item);
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected verdict acc=%0b ovf=%0b lim=%0b, expected none",
                   $time, out_item.accepted, out_item.stack_overflowed,
                   out_item.limit_reached);
          error_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_item.accepted !== want.accepted ||
              out_item.stack_overflowed !== want.stack_overflowed ||
              out_item.limit_reached !== want.limit_reached) begin
            $display({"%0t: verdict mismatch, expected acc=%0b ovf=%0b lim=%0b,",
                      " got acc=%0b ovf=%0b lim=%0b"},
                     $time, want.accepted, want.stack_overflowed, want.limit_reached,
                     out_item.accepted, out_item.stack_overflowed, out_item.limit_reached);
            error_count++;
          end
        end
      end
    end
  end

  // Driver: feed queued items at the falling edge, random idle and result stall
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || item_taken) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Item with every field random and the given operation
  function automatic in_item_t filler(input opcode_t op);
    in_item_t item;
    item.opcode           = op;
    item.key_state        = STATE_W'($urandom_range(15));
    item.key_top          = SYM_W'($urandom_range(15));
    item.character        = CHAR_W'($urandom_range(255));
    item.entry_valid      = 1'($urandom_range(1));
    item.entry_next_state = STATE_W'($urandom_range(15));
    item.entry_push_count = COUNT_W'($urandom_range(7));
    item.push_first       = SYM_W'($urandom_range(15));
    item.push_second      = SYM_W'($urandom_range(15));
    item.push_third       = SYM_W'($urandom_range(15));
    item.push_fourth      = SYM_W'($urandom_range(15));
    return item;
  endfunction

  function automatic in_item_t char_item(input logic [CHAR_W-1:0] ch);
    in_item_t item;
    item           = filler(OP_CHAR);
    item.character = ch;
    return item;
  endfunction

  function automatic in_item_t entry_item(
    input logic [STATE_W-1:0] st, input logic [SYM_W-1:0] top,
    input logic [CHAR_W-1:0] ch, input logic ok, input logic [STATE_W-1:0] nxt,
    input logic [COUNT_W-1:0] cnt, input logic [SYM_W-1:0] s0, input logic [SYM_W-1:0] s1,
    input logic [SYM_W-1:0] s2, input logic [SYM_W-1:0] s3);
    in_item_t item;
    item.opcode           = OP_WRITE;
    item.key_state        = st;
    item.key_top          = top;
    item.character        = ch;
    item.entry_valid      = ok;
    item.entry_next_state = nxt;
    item.entry_push_count = cnt;
    item.push_first       = s0;
    item.push_second      = s1;
    item.push_third       = s2;
    item.push_fourth      = s3;
    return item;
  endfunction

  function automatic logic [STATE_W-1:0] pick_state();
    if ($urandom_range(99) < 90) return live_states[$urandom_range(2)];
    return STATE_W'($urandom_range(15));
  endfunction

  function automatic logic [SYM_W-1:0] pick_symbol();
    if ($urandom_range(99) < 90) return live_syms[$urandom_range(2)];
    return SYM_W'($urandom_range(15));
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    if ($urandom_range(99) < 85) return live_chars[$urandom_range(2)];
    return CHAR_W'($urandom_range(255));
  endfunction

  // Table entry over the live alphabet; short pushes dominate to keep stacks shallow
  function automatic in_item_t random_entry();
    logic [CHAR_W-1:0]  ch;
    logic [COUNT_W-1:0] cnt;
    int                 r;
    r = $urandom_range(99);
    if (r < 25) ch = END_MARK;
    else if (r < 90) ch = live_chars[$urandom_range(2)];
    else ch = CHAR_W'($urandom_range(255));
    r = $urandom_range(99);
    if (r < 25) cnt = 0;
    else if (r < 60) cnt = 1;
    else if (r < 82) cnt = 2;
    else if (r < 92) cnt = 3;
    else cnt = COUNT_W'($urandom_range(4, 7));
    return entry_item(pick_state(), pick_symbol(), ch, ($urandom_range(99) < 85),
                      pick_state(), cnt, pick_symbol(), pick_symbol(), pick_symbol(),
                      pick_symbol());
  endfunction

  task automatic queue_item(input in_item_t item);
    pending_items = {pending_items, item};
    queued_count++;
  endtask

  // One register write on the configuration channel
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until all items are sent and all verdicts are back, then let the core settle
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_verdicts.size() != 0);
    repeat (20) @(negedge clk);
  endtask

  // Run limit
  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main sequence
  initial begin
    int          idx;
    int          phase;
    int          phase_start;
    int          len;
    int          k;
    logic [15:0] mask;
    logic [15:0] limit;

    rst          = 1'b1;
    in_valid     = 1'b0;
    in_item      = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    queued_count = 0;
    error_count  = 0;
    send_idle_pct = 0;
    stall_pct     = 0;

    // shadow reset
    for (idx = 0; idx < TABLE_DEPTH; idx++) shadow_table[idx] = '0;
    shadow_sp        = 0;
    shadow_state     = '0;
    input_left       = 1'b0;
    run_stopped      = 1'b0;
    char_seen        = 1'b0;
    overflow_hit     = 1'b0;
    limit_hit        = 1'b0;
    reg_start_state  = '0;
    reg_start_symbol = '0;
    reg_accept_mask  = '0;
    reg_step_limit   = STEP_LIMIT_RESET;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: start state 3, start symbol 5, states 3 and 15 accept, limit 4
    write_reg(CFG_START_STATE, 16'd3);
    write_reg(CFG_START_SYMBOL, 16'd5);
    write_reg(CFG_ACCEPT_MASK, 16'h8008);
    write_reg(CFG_STEP_LIMIT, 16'd4);
    // end and character with no start: empty stack, state zero
    queue_item(filler(OP_END));
    queue_item(char_item(8'h00));
    queue_item(filler(OP_END));
    // oversized push count saturates; pop-only end-marker step; invalid entry at max key
    queue_item(entry_item(4'd3, 4'd5, 8'h61, 1'b1, 4'd15, 3'd7, 4'd1, 4'd2, 4'd3, 4'd4));
    queue_item(entry_item(4'd15, 4'd1, END_MARK, 1'b1, 4'd15, 3'd0, 4'd0, 4'd0, 4'd0, 4'd0));
    queue_item(entry_item(4'd15, 4'd15, 8'hFF, 1'b0, 4'd15, 3'd7, 4'd15, 4'd15, 4'd15,
                          4'd15));
    // accepted word, then a repeated end
    queue_item(filler(OP_START));
    queue_item(char_item(8'h61));
    queue_item(filler(OP_END));
    queue_item(filler(OP_END));
    // empty word after start
    queue_item(filler(OP_START));
    queue_item(filler(OP_END));
    // missing transition, then a character after the halt
    queue_item(filler(OP_START));
    queue_item(char_item(8'hFF));
    queue_item(char_item(8'h61));
    queue_item(filler(OP_END));
    // end-marker self loop runs into the step limit
    queue_item(entry_item(4'd3, 4'd5, 8'h00, 1'b1, 4'd3, 3'd1, 4'd5, 4'd0, 4'd0, 4'd0));
    queue_item(entry_item(4'd3, 4'd5, END_MARK, 1'b1, 4'd3, 3'd1, 4'd5, 4'd0, 4'd0, 4'd0));
    queue_item(filler(OP_START));
    queue_item(char_item(8'h00));
    queue_item(filler(OP_END));
    wait_idle();

    // Step limit 1024: growing end-marker walk overflows, self loop hits the limit
    write_reg(CFG_STEP_LIMIT, 16'd1024);
    queue_item(entry_item(4'd3, 4'd5, 8'h01, 1'b1, 4'd4, 3'd1, 4'd5, 4'd0, 4'd0, 4'd0));
    queue_item(entry_item(4'd4, 4'd5, END_MARK, 1'b1, 4'd4, 3'd4, 4'd5, 4'd5, 4'd5, 4'd5));
    queue_item(filler(OP_START));
    queue_item(char_item(8'h01));
    queue_item(filler(OP_END));
    queue_item(filler(OP_START));
    queue_item(char_item(8'h00));
    queue_item(filler(OP_END));
    wait_idle();

    // Limit of zero lets no end-marker transition fire
    write_reg(CFG_STEP_LIMIT, 16'd0);
    queue_item(filler(OP_START));
    queue_item(char_item(8'h00));
    queue_item(filler(OP_END));
    wait_idle();

    // Random phases: fresh live alphabet and settings, rotating idle patterns
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 87; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 87; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      for (k = 0; k < 3; k++) begin
        live_states[k] = STATE_W'($urandom_range(15));
        live_syms[k]   = SYM_W'($urandom_range(15));
        live_chars[k]  = CHAR_W'($urandom_range(255));
      end
      if (phase == 1) begin
        live_states[0] = '0;
        live_syms[0]   = '0;
      end else if (phase == 2) begin
        live_states[0] = '1;
        live_syms[0]   = '1;
      end
      if (phase == 1) mask = 16'h0000;
      else if (phase == 2) mask = 16'hFFFF;
      else mask = 16'($urandom_range(65535));
      if (phase == 3) limit = 16'd1;
      else if (phase == 5) limit = 16'd1024;
      else limit = 16'($urandom_range(2, 40));
      write_reg(CFG_START_STATE, 16'(live_states[0]));
      write_reg(CFG_START_SYMBOL, 16'(live_syms[0]));
      write_reg(CFG_ACCEPT_MASK, mask);
      write_reg(CFG_STEP_LIMIT, limit);

      phase_start = queued_count;
      for (k = 0; k < 24; k++) queue_item(random_entry());
      while (queued_count - phase_start < 150) begin
        if ($urandom_range(99) < 6) begin
          // noise: any operation, any content
          queue_item(filler(opcode_t'($urandom_range(3))));
        end else begin
          // word: usually started, some stray characters, occasional repeated end
          if ($urandom_range(99) < 92) queue_item(filler(OP_START));
          len = $urandom_range(0, 8);
          for (k = 0; k < len; k++) queue_item(char_item(pick_char()));
          if ($urandom_range(99) < 10) queue_item(char_item(CHAR_W'($urandom_range(255))));
          queue_item(filler(OP_END));
          if ($urandom_range(99) < 8) queue_item(filler(OP_END));
        end
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[pushdown_automaton_recognizer_core.f]
design/pdar_pkg.sv
design/pdar_ram.sv
design/pdar_stack_cell.sv
design/pdar_stack.sv
design/pushdown_automaton_recognizer_core.sv
tb/tb_pushdown_automaton_recognizer_core.sv
